// ===== hw/rtl/ftb_pkg.sv =====
// Shared constants, codes and types of the fragment tile binner.
`timescale 1ns / 1ps
`default_nettype none

package ftb_pkg;

    // Coordinate, identifier and tile index width
    localparam int DATA_W    = 32;
    // Step counter of the bit-serial divider
    localparam int DIV_CNT_W = $clog2(DATA_W);
    // Configuration register index width
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_END   = 3'd1,
        REG_INDEX_BASE   = 3'd2,
        REG_BIN_WIDTH    = 3'd3,
        REG_COUNT_MODE   = 3'd4
    } cfg_reg_t;

    // Count mode codes
    localparam logic MODE_INSERTION = 1'b0;
    localparam logic MODE_FRAGMENT  = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } ftb_state_t;

    // Divider request
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // Divider status
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    // One result item
    typedef struct packed {
        logic              run_last;
        logic              from_end;
        logic [DATA_W-1:0] tile_index;
        logic [DATA_W-1:0] owner_id;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ftb_divider.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ftb_divider
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ftb_pkg::div_req_t req,
    output ftb_pkg::div_rsp_t      rsp
);

    logic                            busy_reg,  busy_next;
    logic                            done_reg,  done_next;
    logic [ftb_pkg::DIV_CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [ftb_pkg::DATA_W-1:0]      acc_reg,   acc_next;
    logic [ftb_pkg::DATA_W-1:0]      rem_reg,   rem_next;
    logic [ftb_pkg::DATA_W:0]        trial;
    logic [ftb_pkg::DATA_W:0]        diff;

    // Shift the next dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, acc_reg[ftb_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, req.divisor};

    // Load on start, step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = req.dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[ftb_pkg::DATA_W])
            begin
                rem_next = diff[ftb_pkg::DATA_W-1:0];
                acc_next = {acc_reg[ftb_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ftb_pkg::DATA_W-1:0];
                acc_next = {acc_reg[ftb_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ftb_pkg::DIV_CNT_W'(ftb_pkg::DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = acc_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ftb_result_reg.sv =====
// Output register holding one result transaction for the master side.
`timescale 1ns / 1ps
`default_nettype none

module ftb_result_reg
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire ftb_pkg::result_t            item,
    output logic                             free,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [2*ftb_pkg::DATA_W-1:0]     m_tdata,  // owner_id, tile_index
    output logic                             m_tuser,  // from_end
    output logic                             m_tlast   // run_last
);

    logic               valid_reg;
    ftb_pkg::result_t   item_reg;

    // Space when empty or when the held transaction leaves this cycle
    assign free = !valid_reg || m_tready;

    // Hold valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            item_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {item_reg.tile_index, item_reg.owner_id};
    assign m_tuser  = item_reg.from_end;
    assign m_tlast  = item_reg.run_last;

endmodule

`default_nettype wire

// ===== hw/rtl/fragment_tile_binner.sv =====
// Top level of the fragment tile binner: window test, sequencer and register file.
//
//  Channel | Role   | Payload (low bits first)                          | Side info
//  s_*     | input  | cell_id, frag_start, frag_end                     | tlast = batch_last
//  m_*     | output | owner_id, tile_index                              | tuser = from_end, tlast = run_last
//  cfg_*   | config | cfg_index selects register, cfg_data holds value  | always ready
//
// An item with no hit is taken in the idle state alone; each hit passes through the shared bit-serial
// divider and then loads the output register, so an item gives zero, one or two results.
// The divider, one quotient bit per cycle over 32 bits, sets the time that each hit takes.
// The input is accepted only while the sequencer is idle; a full output register stalls
// the sequencer before it loads, never the result already held.
// Reset clears control state and sets the registers to their reset values (bin width 1).
`timescale 1ns / 1ps
`default_nettype none

module fragment_tile_binner
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [3*ftb_pkg::DATA_W-1:0]    s_tdata,   // cell_id, frag_start, frag_end
    input  wire logic                            s_tlast,   // batch_last
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [2*ftb_pkg::DATA_W-1:0]         m_tdata,   // owner_id, tile_index
    output logic                                 m_tuser,   // from_end
    output logic                                 m_tlast,   // run_last
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ftb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ftb_pkg::DATA_W-1:0]      cfg_data
);

    localparam int W = ftb_pkg::DATA_W;

    ftb_pkg::ftb_state_t  state_reg, state_next;

    logic [W-1:0]  window_start_reg;
    logic [W-1:0]  window_end_reg;
    logic [W-1:0]  index_base_reg;
    logic [W-1:0]  bin_width_reg;
    logic          count_mode_reg;
    logic          stopped_reg;

    logic [W-1:0]  cell_reg;
    logic [W-1:0]  off_e_reg;
    logic          hit_e_reg;
    logic          phase_reg;

    logic [W-1:0]  in_cell;
    logic [W-1:0]  in_start;
    logic [W-1:0]  in_end;
    logic          in_accept;
    logic          stop_now;
    logic          hit_s_in;
    logic          hit_e_in;
    logic [W-1:0]  off_s_in;
    logic [W-1:0]  off_e_in;

    ftb_pkg::div_req_t  div_req;
    ftb_pkg::div_rsp_t  div_rsp;
    ftb_pkg::result_t   out_item;
    logic               out_load;
    logic               out_free;
    logic               next_is_end;

    assign in_cell   = s_tdata[W-1:0];
    assign in_start  = s_tdata[2*W-1:W];
    assign in_end    = s_tdata[3*W-1:2*W];
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Window test on the incoming fragment
    always_comb
    begin
        stop_now = stopped_reg || (in_start >= window_end_reg);
        hit_s_in = !stop_now && (in_start >= window_start_reg);
        hit_e_in = !stop_now && (in_end > window_start_reg) && (in_end <= window_end_reg)
                   && !((count_mode_reg == ftb_pkg::MODE_FRAGMENT) && hit_s_in);
        off_s_in = in_start - window_start_reg;
        // end - 1 - start folds into one add with the inverted start
        off_e_in = in_end + ~window_start_reg;
    end

    // Pending end hit after the current result
    assign next_is_end = !phase_reg && hit_e_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftb_pkg::ST_IDLE:
            begin
                if (in_accept && (hit_s_in || hit_e_in))
                begin
                    state_next = ftb_pkg::ST_DIVIDE;
                end
            end
            ftb_pkg::ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    state_next = ftb_pkg::ST_EMIT;
                end
            end
            ftb_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = next_is_end ? ftb_pkg::ST_DIVIDE : ftb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftb_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = off_e_reg;
        div_req.divisor  = bin_width_reg;
        unique case (state_reg)
            ftb_pkg::ST_IDLE:
            begin
                s_tready         = 1'b1;
                div_req.start    = in_accept && (hit_s_in || hit_e_in);
                div_req.dividend = hit_s_in ? off_s_in : off_e_in;
            end
            ftb_pkg::ST_DIVIDE:
            begin
            end
            ftb_pkg::ST_EMIT:
            begin
                out_load      = 1'b1;
                div_req.start = out_free && next_is_end;
            end
            default:
            begin
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        out_item.owner_id   = cell_reg;
        out_item.tile_index = index_base_reg + div_rsp.quotient;
        out_item.from_end   = phase_reg;
        out_item.run_last   = !next_is_end;
    end

    // State and batch stop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ftb_pkg::ST_IDLE;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                stopped_reg <= stop_now && !s_tlast;
            end
        end
    end

    // Item context and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            hit_e_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg <= !hit_s_in;
            hit_e_reg <= hit_e_in;
        end
        else if (div_req.start)
        begin
            phase_reg <= 1'b1;
        end
    end

    // Fragment payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cell_reg  <= in_cell;
            off_e_reg <= off_e_in;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
            window_end_reg   <= '0;
            index_base_reg   <= '0;
            bin_width_reg    <= W'(1);
            count_mode_reg   <= ftb_pkg::MODE_INSERTION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ftb_pkg::cfg_reg_t'(cfg_index))
                ftb_pkg::REG_WINDOW_START: window_start_reg <= cfg_data;
                ftb_pkg::REG_WINDOW_END:   window_end_reg   <= cfg_data;
                ftb_pkg::REG_INDEX_BASE:   index_base_reg   <= cfg_data;
                ftb_pkg::REG_BIN_WIDTH:    bin_width_reg    <= cfg_data;
                ftb_pkg::REG_COUNT_MODE:   count_mode_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    ftb_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ftb_result_reg u_result
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // Divider is never restarted mid-division
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // Done follows each start once the divider has stepped through every quotient bit
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> ##33 div_rsp.done)
        else $error("divider latency broken");

    // No input transaction taken while the divider works on a fragment
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftb_pkg::ST_DIVIDE) |-> !s_tready)
        else $error("input accepted during division");

    // A result only leaves the sequencer once its quotient has settled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_free) |-> !div_rsp.busy)
        else $error("result loaded with divider busy");
`endif

endmodule

`default_nettype wire
